// File: rtl/core/ipap_pkg.sv
package ipap_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_IPV4     = 2'd0,
        KIND_LOOPBACK = 2'd1,
        KIND_INVALID  = 2'd2
    } result_kind_t;

    // Character codes the parser reacts to
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [11:0] OCTET_MAX = 12'd255;
    localparam logic [20:0] PORT_MAX  = 21'd65535;
    localparam logic [16:0] PORT_SAT  = 17'd65536;

    localparam logic [3:0] KW_SHORT_LEN = 4'd5;
    localparam logic [3:0] KW_LONG_LEN  = 4'd8;
    localparam logic [3:0] KW_POS_MAX   = 4'd15;
    localparam logic [2:0] OCTETS_NEEDED = 3'd4;

    // One input transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_string;
    } char_item_t;

    // One result transaction
    typedef struct packed {
        result_kind_t result_kind;
        logic [31:0]  address;
        logic [15:0]  port_number;
    } result_item_t;

    // Parser state carried between characters
    typedef struct packed {
        logic            in_port_part;
        logic [7:0]      octet_accum;
        logic            octet_digit_seen;
        logic [2:0]      octet_count;
        logic [3:0][7:0] octet_store;
        logic [16:0]     port_accum;
        logic            port_minus;
        logic            port_digit_seen;
        logic            port_digits_ended;
        logic            failed;
        logic [3:0]      keyword_position;
        logic [1:0]      keyword_alive;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        in_port_part:      1'b0,
        octet_accum:       8'd0,
        octet_digit_seen:  1'b0,
        octet_count:       3'd0,
        octet_store:       32'd0,
        port_accum:        17'd0,
        port_minus:        1'b0,
        port_digit_seen:   1'b0,
        port_digits_ended: 1'b0,
        failed:            1'b0,
        keyword_position:  4'd0,
        keyword_alive:     2'b11
    };

    // "local"
    function automatic logic [7:0] kw_short_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h63;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h6C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "loopback"
    function automatic logic [7:0] kw_long_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h70;
            3'd4:    ch = 8'h62;
            3'd5:    ch = 8'h61;
            3'd6:    ch = 8'h63;
            3'd7:    ch = 8'h6B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/ipap_char_if.sv
interface ipap_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_string;

    modport source (output valid, output char_code, output last_char,
                    output empty_string, input ready);
    modport sink   (input valid, input char_code, input last_char,
                    input empty_string, output ready);
endinterface

// File: rtl/core/ipap_result_if.sv
interface ipap_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [15:0] port_number;

    modport source (output valid, output result_kind, output address,
                    output port_number, input ready);
    modport sink   (input valid, input result_kind, input address,
                    input port_number, output ready);
endinterface

// File: rtl/core/ipv4_address_port_parser_core.sv
// A result passes through the input register and then the output register after
// its last character (or empty marker) is accepted.
// Throughput: one character per cycle unless stalled; the parser update is one
// pass of a multiply by ten and compares between the input and result registers.
// A result held by the sink stalls the input register until it is taken.
// Reset (rst_n low, asynchronous) empties both registers and clears the parser.
module ipv4_address_port_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    ipap_char_if.sink     char_in,
    ipap_result_if.source result_out
);
    import ipap_pkg::*;

    logic         item_valid;
    char_item_t   item;
    logic         can_take;
    logic         advance;
    logic         res_valid;
    result_item_t res;

    // Character leaves the input register when the result side has room
    assign advance = item_valid && can_take;

    ipap_char_stage u_char_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ipap_parse_engine u_parse_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ipap_result_stage u_result_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .res        (res),
        .can_take   (can_take),
        .result_out (result_out)
    );

endmodule

// File: rtl/core/ipap_char_stage.sv
module ipap_char_stage (
    input  logic                clk,
    input  logic                rst_n,
    ipap_char_if.sink           char_in,
    input  logic                advance,
    output logic                item_valid,
    output ipap_pkg::char_item_t item
);
    import ipap_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       take;

    // Input register: refills in the same cycle it drains
    assign char_in.ready = !valid_reg || advance;
    assign take          = char_in.valid && char_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_code    <= char_in.char_code;
            item_reg.last_char    <= char_in.last_char;
            item_reg.empty_string <= char_in.empty_string;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/ipap_parse_engine.sv
module ipap_parse_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  ipap_pkg::char_item_t   item,
    output logic                   res_valid,
    output ipap_pkg::result_item_t res
);
    import ipap_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t s;
    parse_state_t mid;
    logic         is_digit;
    logic [3:0]   digit;
    logic [11:0]  octet_prod;
    logic [20:0]  port_prod;
    logic         ends_string;

    // Close one octet on '.', ':' or end of host part
    function automatic parse_state_t close_octet(input parse_state_t st);
        parse_state_t r;
        r = st;
        if (!st.octet_digit_seen || st.octet_count >= OCTETS_NEEDED)
        begin
            r.failed = 1'b1;
        end
        else
        begin
            r.octet_store[2'd3 - st.octet_count[1:0]] = st.octet_accum;
            r.octet_count = st.octet_count + 3'd1;
        end
        r.octet_accum      = 8'd0;
        r.octet_digit_seen = 1'b0;
        return r;
    endfunction

    function automatic parse_state_t close_host(input parse_state_t st);
        parse_state_t r;
        r = close_octet(st);
        if (r.octet_count != OCTETS_NEEDED)
        begin
            r.failed = 1'b1;
        end
        return r;
    endfunction

    assign is_digit    = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
    assign digit       = item.char_code[3:0];
    assign octet_prod  = {4'd0, state_reg.octet_accum} * 12'd10 + {8'd0, digit};
    assign port_prod   = {4'd0, state_reg.port_accum} * 21'd10 + {17'd0, digit};
    assign ends_string = item.last_char || item.empty_string;

    // Per-character update and result formation
    always_comb
    begin
        s   = state_reg;
        res = '{result_kind: KIND_INVALID, address: 32'd0, port_number: 16'd0};

        // Keyword tracking
        if (state_reg.keyword_position >= KW_SHORT_LEN
            || kw_short_char(state_reg.keyword_position[2:0]) != item.char_code)
        begin
            s.keyword_alive[0] = 1'b0;
        end
        if (state_reg.keyword_position >= KW_LONG_LEN
            || kw_long_char(state_reg.keyword_position[2:0]) != item.char_code)
        begin
            s.keyword_alive[1] = 1'b0;
        end
        if (state_reg.keyword_position < KW_POS_MAX)
        begin
            s.keyword_position = state_reg.keyword_position + 4'd1;
        end

        if (!state_reg.in_port_part)
        begin
            // Host part
            if (is_digit)
            begin
                if (octet_prod > OCTET_MAX)
                begin
                    s.failed      = 1'b1;
                    s.octet_accum = OCTET_MAX[7:0];
                end
                else
                begin
                    s.octet_accum = octet_prod[7:0];
                end
                s.octet_digit_seen = 1'b1;
            end
            else if (item.char_code == CHAR_DOT)
            begin
                s = close_octet(s);
            end
            else if (item.char_code == CHAR_COLON)
            begin
                s = close_host(s);
                s.in_port_part = 1'b1;
            end
            else
            begin
                s.failed = 1'b1;
            end
        end
        else
        begin
            // Port part
            if (state_reg.port_digits_ended)
            begin
                if (item.char_code == CHAR_COLON)
                begin
                    s.failed = 1'b1;
                end
            end
            else if (state_reg.port_digit_seen)
            begin
                if (is_digit)
                begin
                    s.port_accum = (port_prod > PORT_MAX) ? PORT_SAT : port_prod[16:0];
                end
                else
                begin
                    s.port_digits_ended = 1'b1;
                    if (item.char_code == CHAR_COLON)
                    begin
                        s.failed = 1'b1;
                    end
                end
            end
            else if (is_digit)
            begin
                s.port_accum      = {13'd0, digit};
                s.port_digit_seen = 1'b1;
            end
            else if (item.char_code == CHAR_MINUS && !state_reg.port_minus)
            begin
                s.port_minus = 1'b1;
            end
            else
            begin
                s.failed = 1'b1;
            end
        end

        // End of string checks
        if (s.in_port_part)
        begin
            if (!s.port_digit_seen || s.port_accum > PORT_MAX[16:0]
                || (s.port_minus && s.port_accum != 17'd0))
            begin
                s.failed = 1'b1;
            end
        end
        else
        begin
            s = close_host(s);
        end

        if (item.empty_string)
        begin
            res.result_kind = KIND_INVALID;
        end
        else if (s.keyword_alive[0] && s.keyword_position == KW_SHORT_LEN)
        begin
            res.result_kind = KIND_LOOPBACK;
        end
        else if (s.keyword_alive[1] && s.keyword_position == KW_LONG_LEN)
        begin
            res.result_kind = KIND_LOOPBACK;
        end
        else if (s.failed)
        begin
            res.result_kind = KIND_INVALID;
        end
        else
        begin
            res.result_kind = KIND_IPV4;
            res.address     = s.octet_store;
            res.port_number = s.in_port_part ? s.port_accum[15:0] : 16'd0;
        end
    end

    // Mid-string characters keep the per-character update; the
    // end-of-string closing above feeds only the result.
    always_comb
    begin
        mid = state_reg;
        mid.keyword_alive    = s.keyword_alive;
        mid.keyword_position = s.keyword_position;
        if (!state_reg.in_port_part)
        begin
            if (is_digit)
            begin
                mid.octet_accum      = (octet_prod > OCTET_MAX) ? OCTET_MAX[7:0]
                                                                : octet_prod[7:0];
                mid.octet_digit_seen = 1'b1;
                mid.failed           = state_reg.failed || (octet_prod > OCTET_MAX);
            end
            else if (item.char_code == CHAR_DOT)
            begin
                mid = close_octet(mid);
            end
            else if (item.char_code == CHAR_COLON)
            begin
                mid = close_host(mid);
                mid.in_port_part = 1'b1;
            end
            else
            begin
                mid.failed = 1'b1;
            end
        end
        else
        begin
            if (state_reg.port_digits_ended)
            begin
                if (item.char_code == CHAR_COLON)
                begin
                    mid.failed = 1'b1;
                end
            end
            else if (state_reg.port_digit_seen)
            begin
                if (is_digit)
                begin
                    mid.port_accum = (port_prod > PORT_MAX) ? PORT_SAT : port_prod[16:0];
                end
                else
                begin
                    mid.port_digits_ended = 1'b1;
                    if (item.char_code == CHAR_COLON)
                    begin
                        mid.failed = 1'b1;
                    end
                end
            end
            else if (is_digit)
            begin
                mid.port_accum      = {13'd0, digit};
                mid.port_digit_seen = 1'b1;
            end
            else if (item.char_code == CHAR_MINUS && !state_reg.port_minus)
            begin
                mid.port_minus = 1'b1;
            end
            else
            begin
                mid.failed = 1'b1;
            end
        end
        state_next = ends_string ? PARSE_RESET : mid;
    end

    assign res_valid = advance && ends_string;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // A finished string leaves the parser in its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && ends_string |=> state_reg == PARSE_RESET)
        else $error("parser state not cleared after end of string");

    // Never more than four octets stored
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.octet_count <= OCTETS_NEEDED)
        else $error("octet count overrun");

    // Port accumulator saturates at one above the largest port
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.port_accum <= PORT_SAT)
        else $error("port accumulator beyond saturation");

    // Address and port are zero unless the result is an address
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind != KIND_IPV4
        |-> res.address == 32'd0 && res.port_number == 16'd0)
        else $error("non-address result carries address or port");

endmodule

// File: rtl/core/ipap_result_stage.sv
module ipap_result_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  ipap_pkg::result_item_t res,
    output logic                   can_take,
    ipap_result_if.source          result_out
);
    import ipap_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    result_item_t res_reg;

    // Output register; free when empty or being drained
    assign can_take = !valid_reg || result_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result_out.valid       = valid_reg;
    assign result_out.result_kind = res_reg.result_kind;
    assign result_out.address     = res_reg.address;
    assign result_out.port_number = res_reg.port_number;

endmodule

// File: sim/tb_ipv4_address_port_parser_core.sv
module tb_ipv4_address_port_parser_core;
    import ipap_pkg::*;

    // Expected-result tracker with its own copy of the address parser
    class ipv4_parse_scoreboard;
        result_item_t expected_q[$];
        int unsigned  error_count;

        logic        port_part;
        logic [7:0]  octet_val;
        logic        octet_has_digit;
        logic [2:0]  octets_done;
        logic [7:0]  octets [4];
        logic [16:0] port_val;
        logic        port_neg;
        logic        port_has_digit;
        logic        port_closed;
        logic        bad;
        logic [3:0]  kw_pos;
        logic        short_alive;
        logic        long_alive;

        function new();
            error_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            port_part       = 1'b0;
            octet_val       = 8'd0;
            octet_has_digit = 1'b0;
            octets_done     = 3'd0;
            foreach (octets[i])
                octets[i] = 8'd0;
            port_val        = 17'd0;
            port_neg        = 1'b0;
            port_has_digit  = 1'b0;
            port_closed     = 1'b0;
            bad             = 1'b0;
            kw_pos          = 4'd0;
            short_alive     = 1'b1;
            long_alive      = 1'b1;
        endfunction

        // An octet ends at '.', ':' or the end of the host part
        function void end_octet();
            if (!octet_has_digit || octets_done >= OCTETS_NEEDED)
                bad = 1'b1;
            else
            begin
                octets[octets_done[1:0]] = octet_val;
                octets_done++;
            end
            octet_val       = 8'd0;
            octet_has_digit = 1'b0;
        endfunction

        function void end_host();
            end_octet();
            if (octets_done != OCTETS_NEEDED)
                bad = 1'b1;
        endfunction

        // Advance the parser by one accepted transaction
        function void note_char(char_item_t it);
            string        short_kw;
            string        long_kw;
            logic [7:0]   c;
            logic         is_digit;
            int unsigned  v;
            result_item_t r;

            short_kw = "local";
            long_kw  = "loopback";
            r = '0;
            if (it.empty_string)
            begin
                r.result_kind = KIND_INVALID;
                expected_q.push_back(r);
                clear_state();
                return;
            end

            c        = it.char_code;
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

            // keyword match runs alongside the address parse
            if (kw_pos >= KW_SHORT_LEN || short_kw[kw_pos] != c)
                short_alive = 1'b0;
            if (kw_pos >= KW_LONG_LEN || long_kw[kw_pos] != c)
                long_alive = 1'b0;
            if (kw_pos < KW_POS_MAX)
                kw_pos++;

            if (!port_part)
            begin
                if (is_digit)
                begin
                    v = octet_val * 10 + (c - CHAR_ZERO);
                    if (v > OCTET_MAX)
                    begin
                        bad = 1'b1;
                        v   = OCTET_MAX;
                    end
                    octet_val       = v[7:0];
                    octet_has_digit = 1'b1;
                end
                else if (c == CHAR_DOT)
                    end_octet();
                else if (c == CHAR_COLON)
                begin
                    end_host();
                    port_part = 1'b1;
                end
                else
                    bad = 1'b1;
            end
            else if (port_closed)
            begin
                if (c == CHAR_COLON)
                    bad = 1'b1;
            end
            else if (port_has_digit)
            begin
                if (is_digit)
                begin
                    v = port_val * 10 + (c - CHAR_ZERO);
                    port_val = (v > PORT_MAX) ? PORT_SAT : v[16:0];
                end
                else
                begin
                    port_closed = 1'b1;
                    if (c == CHAR_COLON)
                        bad = 1'b1;
                end
            end
            else if (is_digit)
            begin
                port_val       = 17'(c - CHAR_ZERO);
                port_has_digit = 1'b1;
            end
            else if (c == CHAR_MINUS && !port_neg)
                port_neg = 1'b1;
            else
                bad = 1'b1;

            if (!it.last_char)
                return;

            // final character: settle the string
            if (port_part)
            begin
                if (!port_has_digit || port_val > PORT_MAX || (port_neg && port_val != 0))
                    bad = 1'b1;
            end
            else
                end_host();

            if ((short_alive && kw_pos == KW_SHORT_LEN) ||
                (long_alive && kw_pos == KW_LONG_LEN))
                r.result_kind = KIND_LOOPBACK;
            else if (bad)
                r.result_kind = KIND_INVALID;
            else
            begin
                r.result_kind = KIND_IPV4;
                r.address     = {octets[0], octets[1], octets[2], octets[3]};
                r.port_number = port_part ? port_val[15:0] : 16'd0;
            end
            expected_q.push_back(r);
            clear_state();
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(result_item_t got);
            result_item_t want;

            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, kind %0d address %h port %0d",
                         $time, got.result_kind, got.address, got.port_number);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                         $time, want.result_kind, got.result_kind);
                error_count++;
            end
            if (got.address !== want.address)
            begin
                $display("%0t: address mismatch, expected %h, actual %h",
                         $time, want.address, got.address);
                error_count++;
            end
            if (got.port_number !== want.port_number)
            begin
                $display("%0t: port_number mismatch, expected %0d, actual %0d",
                         $time, want.port_number, got.port_number);
                error_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ipap_char_if   char_if ();
    ipap_result_if result_if ();

    ipv4_address_port_parser_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_if),
        .result_out (result_if)
    );

    ipv4_parse_scoreboard sb = new();

    logic [7:0]  text_q[$];
    bit          steady;
    int unsigned chars_sent;

    string directed_cases[] = '{
        "0.0.0.0", "255.255.255.255:65535", "256.1.2.3", "1..2.3.4", "1.2.3",
        "1.2.3.4.5", "1.2.3.4:-0", "1.2.3.4:-7", "1.2.3.4:-", "1.2.3.4:",
        "1.2.3.4:x1", "1.2.3.4:65536", "1.2.3.4:80/path", "1.2.3.4:80:",
        "1.2.3.4:80x:9", "1.2.3.4::80", "10.a.0.1", "local", "loopback",
        "localhost", "loop", "9.8.7.6:1234"
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void add_octet();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            add_text("0");
        else if (r < 20)
            add_text("255");
        else if (r < 25)
            add_text($sformatf("%0d", $urandom_range(256, 999)));
        else if (r < 28)
            add_text($sformatf("%03d", $urandom_range(0, 99)));
        else if (r < 30)
            add_text("2550");
        else
            add_text($sformatf("%0d", $urandom_range(0, 255)));
    endfunction

    function automatic void add_port();
        int unsigned r;
        logic [7:0]  b;
        text_q.push_back(CHAR_COLON);
        if ($urandom_range(0, 99) < 8)
            text_q.push_back(CHAR_MINUS);
        r = $urandom_range(0, 99);
        if (r < 10)
            add_text("0");
        else if (r < 20)
            add_text("65535");
        else if (r < 25)
            add_text("65536");
        else if (r < 28)
            add_text("999999");
        else if (r < 50)
            add_text($sformatf("%0d", $urandom_range(0, 99)));
        else
            add_text($sformatf("%0d", $urandom_range(0, 65535)));
        // trailing bytes after the port digits
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 4))
            begin
                b = $urandom_range(0, 255);
                if (b == CHAR_COLON)
                    b = b + 8'd1;
                text_q.push_back(b);
            end
            if ($urandom_range(0, 99) < 20)
                text_q.push_back(CHAR_COLON);
        end
    endfunction

    function automatic void build_address(int unsigned n_octets);
        for (int i = 0; i < n_octets; i++)
        begin
            if (i > 0)
                text_q.push_back(CHAR_DOT);
            add_octet();
        end
        if ($urandom_range(0, 1))
            add_port();
    endfunction

    // Replace, insert or drop one byte
    function automatic void damage_text();
        int unsigned pos;
        if (text_q.size() == 0)
        begin
            text_q.push_back($urandom_range(0, 255));
            return;
        end
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
            0: text_q[pos] = $urandom_range(0, 255);
            1: text_q.insert(pos, $urandom_range(0, 255));
            default:
                if (text_q.size() > 1)
                    text_q.delete(pos);
        endcase
    endfunction

    // One transaction on the character channel
    task automatic drive_char(input logic [7:0] code, input logic last, input logic empty);
        int unsigned gap;
        char_item_t  it;
        gap = pick_gap();
        if (gap > 0)
        begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_if.valid        <= 1'b1;
        char_if.char_code    <= code;
        char_if.last_char    <= last;
        char_if.empty_string <= empty;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        it.char_code    = code;
        it.last_char    = last;
        it.empty_string = empty;
        sb.note_char(it);
        chars_sent++;
    endtask

    // Send the buffered string; abandoned or empty strings end with an empty marker
    task automatic send_text(input bit abandon);
        steady = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < text_q.size(); i++)
            drive_char(text_q[i], !abandon && (i == text_q.size() - 1), 1'b0);
        if (abandon || text_q.size() == 0)
            drive_char($urandom_range(0, 255), $urandom_range(0, 1), 1'b1);
        text_q.delete();
    endtask

    // Stimulus and end of run
    initial
    begin
        int unsigned r;

        chars_sent           = 0;
        steady               = 1'b0;
        rst_n               <= 1'b0;
        char_if.valid       <= 1'b0;
        char_if.char_code   <= 8'd0;
        char_if.last_char   <= 1'b0;
        char_if.empty_string <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings
        foreach (directed_cases[i])
        begin
            add_text(directed_cases[i]);
            send_text(1'b0);
        end
        // empty marker wins over last_char, and aborts a partial string
        drive_char(CHAR_NINE, 1'b1, 1'b1);
        add_text("1.2");
        send_text(1'b1);

        // random strings, mostly well formed
        while (chars_sent < 650)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                build_address(4);
                send_text(1'b0);
            end
            else if (r < 75)
            begin
                build_address($urandom_range(1, 6));
                damage_text();
                send_text(1'b0);
            end
            else if (r < 85)
            begin
                case ($urandom_range(0, 7))
                    0: add_text("local");
                    1: add_text("loopback");
                    2: add_text("loca");
                    3: add_text("loopbac");
                    4: add_text("localhost");
                    5: add_text("Local");
                    6: add_text("localloopback");
                    default: add_text("loopback1");
                endcase
                if ($urandom_range(0, 3) == 0)
                    damage_text();
                send_text(1'b0);
            end
            else if (r < 90)
            begin
                if ($urandom_range(0, 1))
                    build_address(4);
                send_text(1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    text_q.push_back($urandom_range(0, 255));
                send_text(1'b0);
            end
        end
        char_if.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.error_count == 0)
            $display("tb_ipv4_address_port_parser_core passed");
        else
            $display("tb_ipv4_address_port_parser_core failed");
        $finish;
    end

    // Result side: random back-pressure, check each transaction
    initial
    begin
        int unsigned  stall_left;
        result_item_t got;

        stall_left       = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got.result_kind = result_kind_t'(result_if.result_kind);
                got.address     = result_if.address;
                got.port_number = result_if.port_number;
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                result_if.ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("tb_ipv4_address_port_parser_core failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/ipap_pkg.sv
rtl/core/ipap_char_if.sv
rtl/core/ipap_result_if.sv
rtl/core/ipap_char_stage.sv
rtl/core/ipap_parse_engine.sv
rtl/core/ipap_result_stage.sv
rtl/core/ipv4_address_port_parser_core.sv
sim/tb_ipv4_address_port_parser_core.sv
